// ===== rtl/ript_pkg.sv =====
// shared types and constants for the range increment point query tree
`timescale 1ns / 1ps

package ript_pkg;

   localparam int LEVELS     = 10;
   localparam int LEAF_COUNT = 1 << LEVELS;
   localparam int NODE_AW    = LEVELS + 1;
   localparam int BOUND_W    = LEVELS + 2;

   localparam logic [1:0] FN_INCREMENT = 2'd0;
   localparam logic [1:0] FN_QUERY     = 2'd1;
   localparam logic [1:0] FN_SEARCH    = 2'd2;
   localparam logic [1:0] FN_RAISE     = 2'd3;

   typedef struct packed {
      logic [1:0]        func;
      logic [LEVELS-1:0] range_low;
      logic [LEVELS-1:0] range_high;
      logic [LEVELS-1:0] position;
      logic [31:0]       threshold;
   } req_type;

   typedef struct packed {
      logic [31:0]       value_out;
      logic [LEVELS-1:0] index_out;
   } rsp_type;

endpackage

// ===== rtl/ript_mem.sv =====
// pending tag memory, one write port and one registered read port
`timescale 1ns / 1ps

module ript_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ript_pkg::NODE_AW-1:0] wr_addr,
   input  logic [31:0]                  wr_data,
   input  logic [ript_pkg::NODE_AW-1:0] rd_addr,
   output logic [31:0]                  rd_data
);

   logic [31:0] mem_ff [0:(1 << ript_pkg::NODE_AW)-1];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/range_increment_point_query_tree.sv =====
// top level of the range increment point query tree
`timescale 1ns / 1ps

// Lazy-tag segment tree over 1024 counters; position p starts at p+1.
// Tags live in a 2048-entry memory with one registered read port, and a
// sequencer drives it one access a cycle. After reset a clearing pass
// zeroes all 2048 tags, during which no request is taken. A point query
// walks the 11 nodes of one root-to-leaf path. A range increment reads
// and then writes back each tagged node, climbing one level at a time.
// A search runs up to 10 point queries; a raise then also increments
// positions 1 to the found index. One request is handled at a time.

module range_increment_point_query_tree (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ript_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ript_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_QRUN, ST_QLAST, ST_SCHK, ST_ACHK, ST_AWR, ST_OUT
   } state_type;

   localparam int LV = ript_pkg::LEVELS;
   localparam int AW = ript_pkg::NODE_AW;
   localparam int BW = ript_pkg::BOUND_W;

   state_type         state_ff, state_in;
   logic [1:0]        func_ff, func_in;
   logic [LV-1:0]     pos_ff, pos_in;
   logic [31:0]       thr_ff, thr_in;
   logic [LV-1:0]     lo_ff, lo_in;
   logic [LV-1:0]     hi_ff, hi_in;
   logic [3:0]        dep_ff, dep_in;
   logic [31:0]       acc_ff, acc_in;
   logic [BW-1:0]     l_ff, l_in;
   logic [BW-1:0]     r_ff, r_in;
   logic [AW-1:0]     tgt_ff, tgt_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ript_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;

   logic [AW-1:0] path;
   logic [31:0]   point_val;
   logic [LV:0]   mid;
   logic [BW-1:0] r_dec;

   ript_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign path      = {1'b1, pos_ff};
   assign point_val = acc_ff + rd_data + 32'(pos_ff) + 32'd1;
   assign mid       = {1'b0, lo_ff}
                      + ((({1'b0, hi_ff} - {1'b0, lo_ff}) + (LV+1)'(1)) >> 1);
   assign r_dec     = r_ff - BW'(1);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      pos_in       = pos_ff;
      thr_in       = thr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      dep_in       = dep_ff;
      acc_in       = acc_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      tgt_in       = tgt_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = tgt_ff;
      wr_data      = rd_data + 32'd1;
      rd_addr      = path >> (4'(LV) - dep_ff);

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 32'd0;
            clr_in  = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in = req_data.func;
               pos_in  = req_data.position;
               thr_in  = req_data.threshold;
               dep_in  = 4'd0;
               acc_in  = 32'd0;
               lo_in   = LV'(1);
               hi_in   = LV'(ript_pkg::LEAF_COUNT - 1);
               case (req_data.func)
                  ript_pkg::FN_INCREMENT: begin
                     l_in = {2'b01, req_data.range_low};
                     r_in = {2'b01, req_data.range_high} + BW'(1);
                     if (req_data.range_low > req_data.range_high) begin
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_ACHK;
                     end
                  end
                  ript_pkg::FN_QUERY: state_in = ST_QRUN;
                  default:            state_in = ST_SCHK;
               endcase
            end
         end
         ST_QRUN: begin
            if (dep_ff != 4'd0) begin
               acc_in = acc_ff + rd_data;
            end
            if (dep_ff == 4'(LV)) begin
               state_in = ST_QLAST;
            end else begin
               dep_in = dep_ff + 4'd1;
            end
         end
         ST_QLAST: begin
            acc_in = point_val;
            if (func_ff == ript_pkg::FN_QUERY) begin
               state_in = ST_OUT;
            end else begin
               if (point_val <= thr_ff) begin
                  lo_in = pos_ff;
               end else begin
                  hi_in = pos_ff - LV'(1);
               end
               state_in = ST_SCHK;
            end
         end
         ST_SCHK: begin
            if (lo_ff < hi_ff) begin
               pos_in   = mid[LV-1:0];
               dep_in   = 4'd0;
               acc_in   = 32'd0;
               state_in = ST_QRUN;
            end else if (func_ff == ript_pkg::FN_RAISE) begin
               l_in     = {2'b01, LV'(1)};
               r_in     = {2'b01, lo_ff} + BW'(1);
               state_in = ST_ACHK;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_ACHK: begin
            if (l_ff >= r_ff) begin
               state_in = ST_OUT;
            end else if (l_ff[0]) begin
               rd_addr  = l_ff[AW-1:0];
               tgt_in   = l_ff[AW-1:0];
               l_in     = l_ff + BW'(1);
               state_in = ST_AWR;
            end else if (r_ff[0]) begin
               rd_addr  = r_dec[AW-1:0];
               tgt_in   = r_dec[AW-1:0];
               r_in     = r_dec;
               state_in = ST_AWR;
            end else begin
               l_in = l_ff >> 1;
               r_in = r_ff >> 1;
            end
         end
         ST_AWR: begin
            wr_en    = 1'b1;
            state_in = ST_ACHK;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.value_out = (func_ff == ript_pkg::FN_QUERY) ? acc_ff : 32'd0;
               rsp_in.index_out = (func_ff == ript_pkg::FN_SEARCH ||
                                   func_ff == ript_pkg::FN_RAISE) ? lo_ff : LV'(0);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      pos_ff  <= pos_in;
      thr_ff  <= thr_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      dep_ff  <= dep_in;
      acc_ff  <= acc_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      tgt_ff  <= tgt_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/tb_range_increment_point_query_tree.sv =====
// testbench for the range increment point query tree: random and directed requests
`timescale 1ns / 1ps

module tb_range_increment_point_query_tree;

   localparam int LIMIT = 2000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ript_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   ript_pkg::rsp_type rsp_data;

   range_increment_point_query_tree uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow tree state
   logic [31:0]       base_value [ript_pkg::LEAF_COUNT];
   logic [31:0]       tag_count [4*ript_pkg::LEAF_COUNT];
   ript_pkg::rsp_type pending_rsp [$];
   int                errors = 0;
   int                cycles = 0;
   int                stall_hold = 0;
   logic              stall_quiet = 1'b0;

   task automatic tag_span(input int node, input int tl, input int tr,
                           input int lo, input int hi);
      int mid;
      if (tr < lo || hi < tl) return;
      if (lo <= tl && tr <= hi) begin
         tag_count[node] = tag_count[node] + 1;
         return;
      end
      mid = tl + (tr - tl) / 2;
      tag_span(2*node+1, tl, mid, lo, hi);
      tag_span(2*node+2, mid+1, tr, lo, hi);
   endtask

   task automatic bump_range(input int lo, input int hi);
      if (lo >= ript_pkg::LEAF_COUNT) return;
      if (hi > ript_pkg::LEAF_COUNT-1) hi = ript_pkg::LEAF_COUNT-1;
      if (lo > hi) return;
      tag_span(0, 0, ript_pkg::LEAF_COUNT-1, lo, hi);
   endtask

   function automatic logic [31:0] point_value(input int p);
      int node, tl, tr, mid;
      logic [31:0] acc;
      node = 0; tl = 0; tr = ript_pkg::LEAF_COUNT-1; acc = '0;
      if (p >= ript_pkg::LEAF_COUNT) return '0;
      while (tl != tr) begin
         acc = acc + tag_count[node];
         mid = tl + (tr - tl) / 2;
         if (p <= mid) begin
            node = 2*node+1; tr = mid;
         end else begin
            node = 2*node+2; tl = mid+1;
         end
      end
      return acc + tag_count[node] + base_value[p];
   endfunction

   function automatic int last_at_most(input logic [31:0] bound);
      int lo, hi, mid;
      lo = 1; hi = ript_pkg::LEAF_COUNT-1;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (point_value(mid) <= bound) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   task automatic apply_request(input ript_pkg::req_type r);
      ript_pkg::rsp_type e;
      int idx;
      e = '0;
      case (r.func)
         ript_pkg::FN_INCREMENT: bump_range(int'(r.range_low), int'(r.range_high));
         ript_pkg::FN_QUERY: e.value_out = point_value(int'(r.position));
         default: begin
            idx = last_at_most(r.threshold);
            e.index_out = idx[ript_pkg::LEVELS-1:0];
            if (r.func == ript_pkg::FN_RAISE) bump_range(1, idx);
         end
      endcase
      pending_rsp.push_back(e);
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
      return $urandom_range(0, 3);
   endfunction

   task automatic send_request(input ript_pkg::req_type r);
      int g;
      g = gap_len();
      repeat (g + 1) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(r);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic ript_pkg::req_type rand_request(input logic [1:0] f);
      ript_pkg::req_type r;
      logic [31:0] u;
      r.func = f;
      u = $urandom;
      r.range_low = u[ript_pkg::LEVELS-1:0];
      u = $urandom;
      r.range_high = u[ript_pkg::LEVELS-1:0];
      u = $urandom;
      r.position = u[ript_pkg::LEVELS-1:0];
      r.threshold = $urandom;
      return r;
   endfunction

   function automatic ript_pkg::req_type mk(input logic [1:0] f, input int lo, input int hi,
                                            input int p, input logic [31:0] t);
      ript_pkg::req_type r;
      r.func = f;
      r.range_low = lo[ript_pkg::LEVELS-1:0];
      r.range_high = hi[ript_pkg::LEVELS-1:0];
      r.position = p[ript_pkg::LEVELS-1:0];
      r.threshold = t;
      return r;
   endfunction

   // result checker and random response stall driver
   always @(posedge clock) begin
      ript_pkg::rsp_type e;
      cycles <= cycles + 1;
      if (!reset) begin
         if (stall_quiet) rsp_stall <= 1'b0;
         else if (stall_hold > 0) begin
            rsp_stall <= 1'b1;
            stall_hold = stall_hold - 1;
         end else if ($urandom_range(0, 199) == 0) begin
            stall_hold = $urandom_range(20, 200);
            rsp_stall <= 1'b1;
         end else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (e.value_out !== rsp_data.value_out) begin
               $display("%0t: value_out expected %h actual %h", $time,
                        e.value_out, rsp_data.value_out);
               errors++;
            end
            if (e.index_out !== rsp_data.index_out) begin
               $display("%0t: index_out expected %0d actual %0d", $time,
                        e.index_out, rsp_data.index_out);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("range_increment_point_query_tree: mismatch");
         $finish;
      end
   end

   task automatic test_directed();
      send_request(mk(ript_pkg::FN_QUERY, 0, 0, 0, 0));
      send_request(mk(ript_pkg::FN_QUERY, 0, 0, 1023, 0));
      send_request(mk(ript_pkg::FN_SEARCH, 0, 0, 0, 0));
      send_request(mk(ript_pkg::FN_SEARCH, 0, 0, 0, 32'hFFFF_FFFF));
      send_request(mk(ript_pkg::FN_SEARCH, 0, 0, 0, 500));
      send_request(mk(ript_pkg::FN_INCREMENT, 0, 1023, 0, 0));
      send_request(mk(ript_pkg::FN_INCREMENT, 700, 3, 0, 0));
      send_request(mk(ript_pkg::FN_INCREMENT, 1023, 1023, 0, 0));
      send_request(mk(ript_pkg::FN_INCREMENT, 5, 5, 0, 0));
      send_request(mk(ript_pkg::FN_INCREMENT, 0, 0, 0, 0));
      send_request(mk(ript_pkg::FN_QUERY, 0, 0, 5, 0));
      send_request(mk(ript_pkg::FN_QUERY, 0, 0, 1023, 0));
      send_request(mk(ript_pkg::FN_QUERY, 0, 0, 0, 0));
      send_request(mk(ript_pkg::FN_RAISE, 0, 0, 0, 300));
      send_request(mk(ript_pkg::FN_RAISE, 0, 0, 0, 0));
      send_request(mk(ript_pkg::FN_INCREMENT, 100, 50, 0, 0));
      send_request(mk(ript_pkg::FN_SEARCH, 0, 0, 0, 300));
      send_request(mk(ript_pkg::FN_QUERY, 0, 0, 200, 0));
      send_request(mk(ript_pkg::FN_INCREMENT, 10, 20, 0, 0));
      send_request(mk(ript_pkg::FN_SEARCH, 0, 0, 0, 18));
   endtask

   task automatic test_drained_pause();
      wait_drained();
      send_request(mk(ript_pkg::FN_QUERY, 0, 0, 512, 0));
      stall_quiet = 1'b1;
      wait_drained();
      stall_quiet = 1'b0;
   endtask

   task automatic test_random();
      ript_pkg::req_type r;
      int sel, n;
      for (n = 0; n < 930; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 3) r = rand_request(ript_pkg::FN_INCREMENT);
         else if (sel < 5) r = rand_request(ript_pkg::FN_QUERY);
         else if (sel < 7) r = rand_request(ript_pkg::FN_SEARCH);
         else r = rand_request(ript_pkg::FN_RAISE);
         // keep thresholds near live values so searches land mid-range
         if (r.func[1] && $urandom_range(0, 3) != 0)
            r.threshold = point_value($urandom_range(1, 1023)) + $urandom_range(0, 4) - 2;
         send_request(r);
      end
   endtask

   initial begin
      int p;
      for (p = 0; p < ript_pkg::LEAF_COUNT; p++) base_value[p] = p + 1;
      for (p = 0; p < 4*ript_pkg::LEAF_COUNT; p++) tag_count[p] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_drained_pause();
      test_random();
      wait_drained();
      if (errors == 0 && pending_rsp.size() == 0)
         $display("range_increment_point_query_tree: match");
      else
         $display("range_increment_point_query_tree: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ript_pkg.sv
rtl/ript_mem.sv
rtl/range_increment_point_query_tree.sv
tb/tb_range_increment_point_query_tree.sv
